// ----- hw/rtl/dte_pkg.sv -----
// Package with the shared types, constants and default parameters of the token expander.
package dte_pkg;

   localparam int DEF_NUM_TOKENS    = 65536;
   localparam int DEF_DICT_BYTES    = 1048576;
   localparam int DEF_MAX_ENTRY_LEN = 16;

   localparam int RES_LIMIT = 16;

   localparam int TYPE_W   = 2;
   localparam int BADDR_W  = 20;
   localparam int BYTE_W   = 8;
   localparam int SLOT_W   = 17;
   localparam int OFFSET_W = 21;
   localparam int TOKEN_W  = 16;

   typedef enum logic [TYPE_W-1:0] {
      REQ_BYTE_WRITE   = 2'd0,
      REQ_OFFSET_WRITE = 2'd1,
      REQ_EXPAND       = 2'd2
   } req_kind_type;

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_START = 4'b0010,
      ST_END   = 4'b0100,
      ST_EMIT  = 4'b1000
   } state_type;

   typedef struct packed {
      logic [BYTE_W-1:0] out_byte;
      logic              last_byte;
      logic              empty_entry;
      logic              truncated;
   } rsp_word_type;

endpackage

// ----- hw/rtl/dte_channels_if.sv -----
// Request and response channel interfaces of the token expander.
interface dte_req_if
   import dte_pkg::*;
   ();
   logic                valid;
   logic                ready;
   logic [TYPE_W-1:0]   req_type;
   logic [BADDR_W-1:0]  byte_address;
   logic [BYTE_W-1:0]   byte_value;
   logic [SLOT_W-1:0]   slot_index;
   logic [OFFSET_W-1:0] slot_offset;
   logic [TOKEN_W-1:0]  token_code;

   modport source (output valid, req_type, byte_address, byte_value, slot_index,
                   slot_offset, token_code, input ready);
   modport sink (input valid, req_type, byte_address, byte_value, slot_index,
                 slot_offset, token_code, output ready);
endinterface

interface dte_rsp_if
   import dte_pkg::*;
   ();
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] out_byte;
   logic              last_byte;
   logic              empty_entry;
   logic              truncated;

   modport source (output valid, out_byte, last_byte, empty_entry, truncated, input ready);
   modport sink (input valid, out_byte, last_byte, empty_entry, truncated, output ready);
endinterface

// ----- hw/rtl/dte_ram.sv -----
// Generic single-write, single-read synchronous RAM with a registered read port.
module dte_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hw/rtl/dte_queue.sv -----
// Two-word output queue that parts the byte read pipeline from the response channel.
module dte_queue
   import dte_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  rsp_word_type push_word,
   input  logic         pop,
   output logic         head_valid,
   output rsp_word_type head_word,
   output logic [1:0]   count
);

   rsp_word_type slot_ff [2];
   logic         wr_ptr_ff, wr_ptr_in;
   logic         rd_ptr_ff, rd_ptr_in;
   logic [1:0]   count_ff, count_in;
   logic         do_pop;

   assign do_pop = pop && (count_ff != 2'd0);

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_word;
      end
   end

   assign head_valid = (count_ff != 2'd0);
   assign head_word  = slot_ff[rd_ptr_ff];
   assign count      = count_ff;

endmodule

// ----- hw/rtl/dictionary_token_expander.sv -----
// Top level of the dictionary token expander: request decode, offset lookup and byte sequencer.
//
// Each request word is a byte write, an offset write or a token to expand. Writes give no
// response. An expand request reads the start and end offsets of its entry from the offset
// RAM, one read per cycle on its single port; after that the sequencer reads one dictionary
// byte per cycle from the byte RAM while the queue has room, and the request side stays busy
// until all n response words (1 to 16) of the token have been read. Responses leave through a
// two-word queue, so a stalled response side holds the sequencer only once that queue and the
// byte read in flight fill its two words. Neither store is cleared at reset: the dictionary
// must be loaded before tokens that refer to it are expanded.
module dictionary_token_expander
   import dte_pkg::*;
#(
   parameter int NUM_TOKENS    = DEF_NUM_TOKENS,
   parameter int DICT_BYTES    = DEF_DICT_BYTES,
   parameter int MAX_ENTRY_LEN = DEF_MAX_ENTRY_LEN
) (
   input logic      clock,
   input logic      reset,
   dte_req_if.sink  req_bus,
   dte_rsp_if.source rsp_bus
);

   localparam int OFF_DEPTH = NUM_TOKENS + 1;
   localparam int OFF_AW    = $clog2(OFF_DEPTH);
   localparam int BYTE_AW   = $clog2(DICT_BYTES);
   localparam int LIM       = (MAX_ENTRY_LEN > RES_LIMIT) ? RES_LIMIT :
                              ((MAX_ENTRY_LEN < 1) ? 1 : MAX_ENTRY_LEN);
   localparam int CNT_W     = $clog2(LIM + 1);
   localparam int ADDR_W    = OFFSET_W + 1;

   state_type            state_ff, state_in;
   logic [TOKEN_W-1:0]   token_ff, token_in;
   logic                 tok_oor_ff, tok_oor_in;
   logic [OFFSET_W-1:0]  start_ff, start_in;
   logic [ADDR_W-1:0]    cur_addr_ff, cur_addr_in;
   logic [CNT_W-1:0]     remain_ff, remain_in;
   logic                 empty_ff, empty_in;
   logic                 trunc_ff, trunc_in;
   logic                 pend_ff, pend_in;
   rsp_word_type         pend_meta_ff, pend_meta_in;

   logic                 accept;
   logic                 byte_wr_en;
   logic                 off_wr_en;
   logic [OFF_AW-1:0]    off_rd_addr;
   logic [OFFSET_W-1:0]  off_rd_data;
   logic [BYTE_W-1:0]    byte_rd_data;
   logic                 issue;
   logic                 credit_ok;
   logic                 pop;
   logic [1:0]           q_count;
   logic                 q_valid;
   rsp_word_type         q_head;
   rsp_word_type         push_word;
   logic [OFFSET_W-1:0]  entry_len;
   logic                 entry_empty;
   logic [SLOT_W-1:0]    tok_ext;
   logic [SLOT_W-1:0]    tok_next;
   logic                 last_issue;

   assign req_bus.ready = (state_ff == ST_IDLE);
   assign accept        = req_bus.valid && req_bus.ready;

   assign byte_wr_en = accept && (req_bus.req_type == REQ_BYTE_WRITE) &&
                       ({1'b0, req_bus.byte_address} < (BADDR_W + 1)'(DICT_BYTES));
   assign off_wr_en  = accept && (req_bus.req_type == REQ_OFFSET_WRITE) &&
                       ({1'b0, req_bus.slot_index} <= (SLOT_W + 1)'(NUM_TOKENS));

   assign tok_ext  = {1'b0, req_bus.token_code};
   assign tok_next = {1'b0, token_ff} + SLOT_W'(1);

   always_comb begin
      case (state_ff)
         ST_START: off_rd_addr = tok_next[OFF_AW-1:0];
         default:  off_rd_addr = tok_ext[OFF_AW-1:0];
      endcase
   end

   dte_ram #(
      .WIDTH (OFFSET_W),
      .DEPTH (OFF_DEPTH)
   ) u_offset_ram (
      .clock   (clock),
      .wr_en   (off_wr_en),
      .wr_addr (req_bus.slot_index[OFF_AW-1:0]),
      .wr_data (req_bus.slot_offset),
      .rd_en   (1'b1),
      .rd_addr (off_rd_addr),
      .rd_data (off_rd_data)
   );

   dte_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (DICT_BYTES)
   ) u_byte_ram (
      .clock   (clock),
      .wr_en   (byte_wr_en),
      .wr_addr (req_bus.byte_address[BYTE_AW-1:0]),
      .wr_data (req_bus.byte_value),
      .rd_en   (issue),
      .rd_addr (cur_addr_ff[BYTE_AW-1:0]),
      .rd_data (byte_rd_data)
   );

   assign entry_len   = off_rd_data - start_ff;
   assign entry_empty = tok_oor_ff || (off_rd_data <= start_ff);

   assign pop       = rsp_bus.valid && rsp_bus.ready;
   assign credit_ok = (({1'b0, q_count} + {2'b0, pend_ff}) < (3'd2 + {2'b0, pop}));
   assign issue     = (state_ff == ST_EMIT) && credit_ok;
   assign last_issue = (remain_ff == CNT_W'(1));

   always_comb begin
      state_in     = state_ff;
      token_in     = token_ff;
      tok_oor_in   = tok_oor_ff;
      start_in     = start_ff;
      cur_addr_in  = cur_addr_ff;
      remain_in    = remain_ff;
      empty_in     = empty_ff;
      trunc_in     = trunc_ff;
      pend_in      = issue;
      pend_meta_in = pend_meta_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && (req_bus.req_type == REQ_EXPAND)) begin
               token_in   = req_bus.token_code;
               tok_oor_in = ({1'b0, req_bus.token_code} >= (TOKEN_W + 1)'(NUM_TOKENS));
               state_in   = ST_START;
            end
         end
         ST_START: begin
            start_in = off_rd_data;
            state_in = ST_END;
         end
         ST_END: begin
            cur_addr_in = {1'b0, start_ff};
            empty_in    = entry_empty;
            trunc_in    = !entry_empty && (entry_len > OFFSET_W'(MAX_ENTRY_LEN));
            if (entry_empty) begin
               remain_in = CNT_W'(1);
            end else if (entry_len > OFFSET_W'(LIM)) begin
               remain_in = CNT_W'(LIM);
            end else begin
               remain_in = entry_len[CNT_W-1:0];
            end
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (issue) begin
               pend_meta_in.out_byte    = '0;
               pend_meta_in.last_byte   = last_issue;
               pend_meta_in.empty_entry = empty_ff;
               pend_meta_in.truncated   = trunc_ff;
               pend_meta_in.out_byte[0] = empty_ff ||
                                          (cur_addr_ff >= ADDR_W'(DICT_BYTES));
               cur_addr_in = cur_addr_ff + ADDR_W'(1);
               remain_in   = remain_ff - CNT_W'(1);
               if (last_issue) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Bit 0 of the pending byte field marks a word whose byte is forced to zero.
   always_comb begin
      push_word             = pend_meta_ff;
      push_word.out_byte    = pend_meta_ff.out_byte[0] ? '0 : byte_rd_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         pend_ff  <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      token_ff     <= token_in;
      tok_oor_ff   <= tok_oor_in;
      start_ff     <= start_in;
      cur_addr_ff  <= cur_addr_in;
      remain_ff    <= remain_in;
      empty_ff     <= empty_in;
      trunc_ff     <= trunc_in;
      pend_meta_ff <= pend_meta_in;
   end

   dte_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (pend_ff),
      .push_word  (push_word),
      .pop        (pop),
      .head_valid (q_valid),
      .head_word  (q_head),
      .count      (q_count)
   );

   assign rsp_bus.valid       = q_valid;
   assign rsp_bus.out_byte    = q_head.out_byte;
   assign rsp_bus.last_byte   = q_head.last_byte;
   assign rsp_bus.empty_entry = q_head.empty_entry;
   assign rsp_bus.truncated   = q_head.truncated;

endmodule

// ----- hw/rtl/dte_checker.sv -----
// Port-level checker for the token expander, bound to the top level.
module dte_checker
   import dte_pkg::*;
(
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic [TYPE_W-1:0] req_type,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic [BYTE_W-1:0] out_byte,
   input logic              last_byte,
   input logic              empty_entry,
   input logic              truncated
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(out_byte) && $stable(last_byte) &&
                                  $stable(empty_entry) && $stable(truncated))
      else $error("A stalled response word changed.");

   a_empty_word: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && empty_entry |-> last_byte && !truncated && (out_byte == '0))
      else $error("An empty response word is malformed.");

   a_expand_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_type == REQ_EXPAND) |=> !req_ready)
      else $error("A request was taken while a token lookup was under way.");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("A response word is shown right after reset.");

endmodule

bind dictionary_token_expander dte_checker u_dte_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_bus.valid),
   .req_ready   (req_bus.ready),
   .req_type    (req_bus.req_type),
   .rsp_valid   (rsp_bus.valid),
   .rsp_ready   (rsp_bus.ready),
   .out_byte    (rsp_bus.out_byte),
   .last_byte   (rsp_bus.last_byte),
   .empty_entry (rsp_bus.empty_entry),
   .truncated   (rsp_bus.truncated)
);

// ----- dv/testbench.sv -----
// Self-checking testbench for the dictionary token expander with its own expansion predictor.
module testbench;
   import dte_pkg::*;

   localparam int NUM_TOKENS    = DEF_NUM_TOKENS;
   localparam int DICT_BYTES    = DEF_DICT_BYTES;
   localparam int MAX_ENTRY_LEN = DEF_MAX_ENTRY_LEN;
   localparam int EMIT_LIMIT    = (MAX_ENTRY_LEN < RES_LIMIT) ? MAX_ENTRY_LEN : RES_LIMIT;

   localparam logic [TYPE_W-1:0] REQ_UNUSED = 2'd3;

   localparam int DIRECTED_COUNT = 25;
   localparam int ITEM_TARGET    = 310;
   localparam int CALM_ITEMS     = 40;
   localparam int LONG_HOLD      = 400;
   localparam int DRAIN_CYCLES   = 3 + RES_LIMIT + 12;
   localparam int TIMEOUT_CYCLES = 600000;

   typedef struct {
      logic [TYPE_W-1:0]   kind;
      logic [BADDR_W-1:0]  byte_address;
      logic [BYTE_W-1:0]   byte_value;
      logic [SLOT_W-1:0]   slot_index;
      logic [OFFSET_W-1:0] slot_offset;
      logic [TOKEN_W-1:0]  token_code;
      bit                  has_word;
      rsp_word_type        word;
   } request_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   dte_req_if req_chan ();
   dte_rsp_if rsp_chan ();

   dictionary_token_expander dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_chan),
      .rsp_bus (rsp_chan)
   );

   logic [BYTE_W-1:0]   dict_image [int unsigned];
   logic [OFFSET_W-1:0] offset_image [int unsigned];
   rsp_word_type        pending_bytes [$];

   int unsigned failures      = 0;
   int unsigned byte_writes   = 0;
   int unsigned offset_writes = 0;
   int unsigned expansions    = 0;
   int unsigned ignored_words = 0;
   int unsigned words_checked = 0;
   bit          calm          = 1'b0;
   bit          hold_pending  = 1'b0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      #(TIMEOUT_CYCLES * 10);
      $display("== FAIL ==");
      $finish;
   end

   function automatic request_type make_row(input logic [TYPE_W-1:0] kind,
                                            input int unsigned addr, input int unsigned value,
                                            input int unsigned slot, input int unsigned offset,
                                            input int unsigned token);
      request_type r;
      r.kind         = kind;
      r.byte_address = BADDR_W'(addr);
      r.byte_value   = BYTE_W'(value);
      r.slot_index   = SLOT_W'(slot);
      r.slot_offset  = OFFSET_W'(offset);
      r.token_code   = TOKEN_W'(token);
      r.has_word     = 1'b0;
      r.word         = '0;
      return r;
   endfunction

   function automatic request_type pinned(input request_type r, input logic [BYTE_W-1:0] b,
                                          input logic last, input logic empty,
                                          input logic trunc);
      request_type p;
      p = r;
      p.has_word = 1'b1;
      p.word     = '{out_byte: b, last_byte: last, empty_entry: empty, truncated: trunc};
      return p;
   endfunction

   function automatic request_type fresh_item(input logic [TYPE_W-1:0] kind);
      return make_row(kind, $urandom_range(0, 2**BADDR_W - 1), $urandom_range(0, 255),
                      $urandom_range(0, 2**SLOT_W - 1), $urandom_range(0, 2**OFFSET_W - 1),
                      $urandom_range(0, 2**TOKEN_W - 1));
   endfunction

   function automatic bit can_expand(input int unsigned token);
      int unsigned head;
      int unsigned tail;
      if (!offset_image.exists(token) || !offset_image.exists(token + 1)) return 1'b0;
      head = offset_image[token];
      tail = offset_image[token + 1];
      for (int unsigned i = 0; tail > head && i < tail - head && i < EMIT_LIMIT; i++) begin
         if (head + i < DICT_BYTES && !dict_image.exists(head + i)) return 1'b0;
      end
      return 1'b1;
   endfunction

   // Updates the dictionary images and queues the words that the block must return.
   function automatic void record_request(input request_type r);
      int unsigned head;
      int unsigned tail;
      int unsigned count;
      int unsigned addr;
      bit          cut;
      rsp_word_type w;
      case (r.kind)
         REQ_BYTE_WRITE: begin
            byte_writes++;
            if (r.byte_address < DICT_BYTES) dict_image[r.byte_address] = r.byte_value;
         end
         REQ_OFFSET_WRITE: begin
            if (r.slot_index <= NUM_TOKENS) begin
               offset_writes++;
               offset_image[r.slot_index] = r.slot_offset;
            end else begin
               ignored_words++;
            end
         end
         REQ_EXPAND: begin
            expansions++;
            if (r.has_word) begin
               pending_bytes = {pending_bytes, r.word};
            end else begin
               head = (r.token_code < NUM_TOKENS) ? offset_image[r.token_code] : 0;
               tail = (r.token_code < NUM_TOKENS) ? offset_image[r.token_code + 1] : 0;
               if (tail <= head) begin
                  w.out_byte    = '0;
                  w.last_byte   = 1'b1;
                  w.empty_entry = 1'b1;
                  w.truncated   = 1'b0;
                  pending_bytes = {pending_bytes, w};
               end else begin
                  cut   = (tail - head) > MAX_ENTRY_LEN;
                  count = ((tail - head) > EMIT_LIMIT) ? EMIT_LIMIT : (tail - head);
                  for (int unsigned i = 0; i < count; i++) begin
                     addr          = head + i;
                     w.out_byte    = (addr < DICT_BYTES) ? dict_image[addr] : '0;
                     w.last_byte   = (i + 1 == count);
                     w.empty_entry = 1'b0;
                     w.truncated   = cut;
                     pending_bytes = {pending_bytes, w};
                  end
               end
            end
         end
         default: ignored_words++;
      endcase
   endfunction

   task automatic send_request(input request_type r);
      if (!calm && $urandom_range(0, 4) == 0) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 19)) @(posedge clock);
      end
      req_chan.valid        <= 1'b1;
      req_chan.req_type     <= r.kind;
      req_chan.byte_address <= r.byte_address;
      req_chan.byte_value   <= r.byte_value;
      req_chan.slot_index   <= r.slot_index;
      req_chan.slot_offset  <= r.slot_offset;
      req_chan.token_code   <= r.token_code;
      @(posedge clock);
      while (req_chan.ready !== 1'b1) @(posedge clock);
      record_request(r);
   endtask

   function automatic void check_field(input string name, input logic [BYTE_W-1:0] want,
                                       input logic [BYTE_W-1:0] got);
      if (got !== want) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
         failures++;
      end
   endfunction

   always @(posedge clock) begin : response_check
      rsp_word_type want;
      if (!reset && rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1) begin
         if (pending_bytes.size() == 0) begin
            $error("response word 0x%0h arrived with nothing expected", rsp_chan.out_byte);
            failures++;
         end else begin
            want = pending_bytes.pop_front();
            words_checked++;
            check_field("out_byte", want.out_byte, rsp_chan.out_byte);
            check_field("last_byte", want.last_byte, rsp_chan.last_byte);
            check_field("empty_entry", want.empty_entry, rsp_chan.empty_entry);
            check_field("truncated", want.truncated, rsp_chan.truncated);
         end
      end
   end

   initial begin : response_pacing
      rsp_chan.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_pending) begin
            hold_pending = 1'b0;
            rsp_chan.ready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
         end else if (!calm && $urandom_range(0, 5) == 0) begin
            rsp_chan.ready <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clock);
         end
         rsp_chan.ready <= 1'b1;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
   end

   initial begin : stimulus
      request_type rows [0:DIRECTED_COUNT-1];
      request_type r;
      int unsigned tok;
      int unsigned head;
      int unsigned tail;
      int unsigned span;
      int unsigned order;
      int unsigned side;
      int unsigned pick;
      int unsigned k;
      int unsigned known_tokens [$];

      req_chan.valid        <= 1'b0;
      req_chan.req_type     <= REQ_BYTE_WRITE;
      req_chan.byte_address <= '0;
      req_chan.byte_value   <= '0;
      req_chan.slot_index   <= '0;
      req_chan.slot_offset  <= '0;
      req_chan.token_code   <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Entry 65535 sits at the top of the store, so most of its bytes fall beyond it.
      rows = '{
         make_row(REQ_BYTE_WRITE, 20'hFFFFF, 8'hFF, 0, 0, 0),
         make_row(REQ_BYTE_WRITE, 20'hFFFFE, 8'h00, 0, 0, 0),
         make_row(REQ_BYTE_WRITE, 20'h00000, 8'hA5, 0, 0, 0),
         make_row(REQ_BYTE_WRITE, 20'h00001, 8'h5A, 0, 0, 0),
         make_row(REQ_OFFSET_WRITE, 0, 0, 0, 0, 0),
         make_row(REQ_OFFSET_WRITE, 0, 0, 1, 1, 0),
         pinned(make_row(REQ_EXPAND, 0, 0, 0, 0, 0), 8'hA5, 1'b1, 1'b0, 1'b0),
         make_row(REQ_OFFSET_WRITE, 0, 0, 2, 2, 0),
         make_row(REQ_OFFSET_WRITE, 0, 0, 3, 0, 0),
         pinned(make_row(REQ_EXPAND, 0, 0, 0, 0, 2), 8'h00, 1'b1, 1'b1, 1'b0),
         make_row(REQ_OFFSET_WRITE, 0, 0, 65535, 21'h0FFFFE, 0),
         make_row(REQ_OFFSET_WRITE, 0, 0, 65536, 21'h1FFFFF, 0),
         make_row(REQ_EXPAND, 0, 0, 0, 0, 16'hFFFF),
         make_row(REQ_OFFSET_WRITE, 0, 0, 17'h1FFFF, 0, 0),
         make_row(REQ_EXPAND, 0, 0, 0, 0, 16'hFFFF),
         make_row(REQ_UNUSED, 20'hFFFFF, 8'hFF, 17'h1FFFF, 21'h1FFFFF, 16'hFFFF),
         make_row(REQ_OFFSET_WRITE, 0, 0, 65536, 21'h100000, 0),
         make_row(REQ_EXPAND, 0, 0, 0, 0, 16'hFFFF),
         make_row(REQ_OFFSET_WRITE, 0, 0, 4, 0, 0),
         pinned(make_row(REQ_EXPAND, 0, 0, 0, 0, 3), 8'h00, 1'b1, 1'b1, 1'b0),
         pinned(make_row(REQ_EXPAND, 0, 0, 0, 0, 1), 8'h5A, 1'b1, 1'b0, 1'b0),
         make_row(REQ_OFFSET_WRITE, 0, 0, 65536, 21'h10000F, 0),
         make_row(REQ_EXPAND, 0, 0, 0, 0, 16'hFFFF),
         make_row(REQ_BYTE_WRITE, 20'hFFFFF, 8'h3C, 0, 0, 0),
         make_row(REQ_EXPAND, 0, 0, 0, 0, 16'hFFFF)
      };
      foreach (rows[i]) send_request(rows[i]);

      hold_pending = 1'b1;
      while (byte_writes + offset_writes + expansions < ITEM_TARGET) begin
         calm = (byte_writes + offset_writes + expansions) >= ITEM_TARGET - CALM_ITEMS;
         pick = $urandom_range(0, 99);
         if (pick < 65) begin
            case ($urandom_range(0, 7))
               0: tok = 0;
               1: tok = NUM_TOKENS - 1;
               default: tok = $urandom_range(0, NUM_TOKENS - 1);
            endcase
            case ($urandom_range(0, 9))
               0: span = 0;
               1, 2: span = $urandom_range(MAX_ENTRY_LEN + 1, 40);
               default: span = $urandom_range(1, MAX_ENTRY_LEN);
            endcase
            case ($urandom_range(0, 7))
               0: head = DICT_BYTES - $urandom_range(1, 8);
               1: head = $urandom_range(DICT_BYTES, 2**OFFSET_W - 64);
               default: head = $urandom_range(0, DICT_BYTES - 1);
            endcase
            tail = head + span;
            if ($urandom_range(0, 9) == 0) begin
               tail = $urandom_range(0, head);
               span = 0;
            end
            for (k = 0; k < span && k < EMIT_LIMIT; k++) begin
               if (head + k < DICT_BYTES) begin
                  r = fresh_item(REQ_BYTE_WRITE);
                  r.byte_address = BADDR_W'(head + k);
                  send_request(r);
               end
            end
            order = $urandom_range(0, 1);
            for (k = 0; k < 2; k++) begin
               side = k ^ order;
               r = fresh_item(REQ_OFFSET_WRITE);
               r.slot_index  = SLOT_W'(tok + side);
               r.slot_offset = OFFSET_W'(side ? tail : head);
               send_request(r);
            end
            repeat ($urandom_range(1, 2)) begin
               r = fresh_item(REQ_EXPAND);
               r.token_code = TOKEN_W'(tok);
               send_request(r);
            end
            known_tokens = {known_tokens, tok};
         end else if (pick < 85 && known_tokens.size() != 0) begin
            tok = known_tokens[$urandom_range(0, known_tokens.size() - 1)];
            if (can_expand(tok)) begin
               r = fresh_item(REQ_EXPAND);
               r.token_code = TOKEN_W'(tok);
               send_request(r);
            end
         end else begin
            case ($urandom_range(0, 3))
               0: r = fresh_item(REQ_UNUSED);
               1: begin
                  r = fresh_item(REQ_OFFSET_WRITE);
                  r.slot_index = SLOT_W'($urandom_range(NUM_TOKENS + 1, 2**SLOT_W - 1));
               end
               2: r = fresh_item(REQ_BYTE_WRITE);
               default: begin
                  r = fresh_item(REQ_OFFSET_WRITE);
                  r.slot_index = SLOT_W'($urandom_range(0, NUM_TOKENS));
               end
            endcase
            send_request(r);
         end
      end
      req_chan.valid <= 1'b0;

      while (pending_bytes.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d byte writes, %0d offset writes, %0d expansions, %0d ignored words.",
               byte_writes, offset_writes, expansions, ignored_words);
      $display("Checked %0d response words, including a long response stall and %0d mismatches.",
               words_checked, failures);
      if (failures == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
